>>> src/tle_pkg.sv
`default_nettype none
package tle_pkg;

    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_ESC    = 8'h1B;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_TILDE  = 8'h7E;

    localparam logic [1:0] ESC_NORMAL  = 2'd0;
    localparam logic [1:0] ESC_AFTER   = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;

    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_CR    = 2'd1;
    localparam logic [1:0] KIND_BS    = 2'd2;

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;
    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] len;
    } t_burst;

endpackage
`default_nettype wire

>>> src/tle_ctrl.sv
`default_nettype none
module tle_ctrl #(
    parameter int unsigned MAX_LINE = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [8:0]    i_capacity,
    input  wire logic          i_load_ready,
    output logic               o_load,
    output tle_pkg::t_burst    o_burst
);
    import tle_pkg::*;

    localparam logic [8:0] CAP_LIMIT = (MAX_LINE < 256) ? 9'(MAX_LINE) : 9'd256;

    logic       r_full;
    logic [7:0] r_byte;
    logic [7:0] r_count;
    logic [1:0] r_esc;

    logic [7:0] n_count;
    logic [1:0] n_esc;
    logic       has_result;
    logic       consume;
    logic       accept;
    logic [8:0] eff_cap;
    t_burst     burst;

    assign eff_cap = (i_capacity > CAP_LIMIT) ? CAP_LIMIT : i_capacity;

    always_comb begin
        n_count    = r_count;
        n_esc      = r_esc;
        has_result = 1'b0;
        burst.kind = KIND_PRINT;
        burst.data = r_byte;
        burst.idx  = 8'd0;
        burst.len  = 8'd0;
        if (eff_cap == 9'd0) begin
            n_esc = ESC_NORMAL;
            if (r_byte == CHR_CR) begin
                has_result = 1'b1;
                burst.kind = KIND_CR;
                n_count    = 8'd0;
            end
        end else if (r_esc == ESC_AFTER) begin
            n_esc = (r_byte == CHR_LBRACK) ? ESC_BRACKET : ESC_NORMAL;
        end else if (r_esc != ESC_NORMAL) begin
            if (r_byte == CHR_TILDE) begin
                n_esc = ESC_NORMAL;
            end
        end else if (r_byte inside {[CHR_SPACE:CHR_TILDE]}) begin
            if ({1'b0, r_count} + 9'd1 < eff_cap) begin
                has_result = 1'b1;
                burst.idx  = r_count;
                n_count    = r_count + 8'd1;
            end
        end else if (r_byte == CHR_CR) begin
            has_result = 1'b1;
            burst.kind = KIND_CR;
            burst.len  = r_count;
            n_count    = 8'd0;
        end else if (r_byte == CHR_BS) begin
            if (r_count != 8'd0) begin
                has_result = 1'b1;
                burst.kind = KIND_BS;
                n_count    = r_count - 8'd1;
            end
        end else if (r_byte == CHR_ESC) begin
            n_esc = ESC_AFTER;
        end
    end

    assign consume    = r_full && (!has_result || i_load_ready);
    assign o_in_stall = r_full && !consume;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_load     = r_full && has_result && i_load_ready;
    assign o_burst    = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= 1'b0;
            r_count <= 8'd0;
            r_esc   <= ESC_NORMAL;
        end else begin
            if (accept) begin
                r_full <= 1'b1;
            end else if (consume) begin
                r_full <= 1'b0;
            end
            if (consume) begin
                r_count <= n_count;
                r_esc   <= n_esc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

>>> src/tle_emit.sv
`default_nettype none
module tle_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire tle_pkg::t_burst i_burst,
    output logic               o_load_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_echo_byte,
    output logic               o_store_write,
    output logic [7:0]         o_store_index,
    output logic               o_line_done,
    output logic [7:0]         o_line_length,
    output logic               o_last
);
    import tle_pkg::*;

    logic       r_valid;
    logic [1:0] r_step;
    t_burst     r_burst;
    logic       xfer;

    always_comb begin
        o_echo_byte = r_burst.data;
        o_last      = 1'b1;
        case (r_burst.kind)
            KIND_PRINT: begin
                o_echo_byte = r_burst.data;
                o_last      = 1'b1;
            end
            KIND_CR: begin
                o_echo_byte = (r_step == 2'd0) ? CHR_CR : CHR_LF;
                o_last      = (r_step != 2'd0);
            end
            KIND_BS: begin
                o_echo_byte = (r_step == 2'd1) ? CHR_SPACE : CHR_BS;
                o_last      = (r_step == 2'd2);
            end
            default: begin
                o_echo_byte = r_burst.data;
                o_last      = 1'b1;
            end
        endcase
    end

    assign o_store_write = (r_burst.kind == KIND_PRINT);
    assign o_store_index = o_store_write ? r_burst.idx : 8'd0;
    assign o_line_done   = (r_burst.kind == KIND_CR) && o_last;
    assign o_line_length = o_line_done ? r_burst.len : 8'd0;
    assign o_out_valid   = r_valid;

    assign xfer         = r_valid && !i_out_stall;
    assign o_load_ready = !r_valid || (xfer && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_step  <= 2'd0;
        end else if (xfer) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule
`default_nettype wire

>>> src/terminal_line_editor.sv
// Terminal line editor: edits one input line from received terminal bytes.
// Input channel: i_in_valid / o_in_stall carry i_rx_byte; a transfer happens
// at a rising edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one echo result per
// transfer (echo byte, line-store write and index, line done and length,
// last marker for the final result of an input byte).
// Capacity register at APB address 0, written with psel, penable, pwrite.
// Each byte goes to the input register, its results to the result register.
// Throughput: one byte per cycle when each byte yields at most one result and
// the output does not stall; a carriage return gives two results (CR, LF) and
// a backspace three (BS, space, BS), one echo per cycle from the single result
// register when not stalled. Bytes with no result never wait on that register.
// Reset (synchronous, active low) empties both registers, clears the stored
// count and escape state, and sets capacity to 256.
// A stall on the output holds the result; the input stalls once the input
// register holds a byte whose results cannot yet be loaded.
`default_nettype none
module terminal_line_editor #(
    parameter int unsigned MAX_LINE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_echo_byte,
    output logic             o_store_write,
    output logic [7:0]       o_store_index,
    output logic             o_line_done,
    output logic [7:0]       o_line_length,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tle_pkg::*;

    logic [8:0] r_capacity;
    logic       load;
    logic       load_ready;
    t_burst     burst;
    logic       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr == {ADDR_CAPACITY, 1'b0});
    assign prdata  = cfg_sel ? {23'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_capacity <= pwdata[8:0];
        end
    end

    tle_ctrl #(
        .MAX_LINE(MAX_LINE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_capacity  (r_capacity),
        .i_load_ready(load_ready),
        .o_load      (load),
        .o_burst     (burst)
    );

    tle_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .o_load_ready (load_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_echo_byte  (o_echo_byte),
        .o_store_write(o_store_write),
        .o_store_index(o_store_index),
        .o_line_done  (o_line_done),
        .o_line_length(o_line_length),
        .o_last       (o_last)
    );

`ifndef SYNTH
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |-> o_last)
        else $error("line done on a result that is not last");

    a_write_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_store_write && o_line_done))
        else $error("store write and line done together");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("result sequence cut short");
`endif

endmodule
`default_nettype wire
